FILE: rtl/core/f2i_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_pkg: shared types and constants for the float to integer converter
// Holds the status codes, the register indexes and the classified item
// that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package f2i_pkg;

    localparam int FloatW  = 64;
    localparam int StatusW = 3;
    localparam int CfgIdxW = 2;
    localparam int CfgDatW = 7;
    localparam int DefQueueDepth = 2;

    localparam logic [CfgIdxW-1:0] REG_SOURCE_WIDTH = 2'd0;
    localparam logic [CfgIdxW-1:0] REG_DEST_WIDTH   = 2'd1;
    localparam logic [CfgIdxW-1:0] REG_DEST_SIGNED  = 2'd2;

    localparam logic [StatusW-1:0] ST_ROUNDED      = 3'd0;
    localparam logic [StatusW-1:0] ST_SAT_MAX      = 3'd1;
    localparam logic [StatusW-1:0] ST_SAT_MIN      = 3'd2;
    localparam logic [StatusW-1:0] ST_NEG_UNSIGNED = 3'd3;
    localparam logic [StatusW-1:0] ST_UNSUPPORTED  = 3'd4;
    localparam logic [StatusW-1:0] ST_NAN          = 3'd5;

    // Destination class: 8, 16, 32 or 64 bits.
    typedef enum logic [1:0] {
        CLS_8  = 2'd0,
        CLS_16 = 2'd1,
        CLS_32 = 2'd2,
        CLS_64 = 2'd3
    } t_cls;

    // Classified item: integer part, round bit and flags.
    typedef struct packed {
        logic               fixed;   // result already decided
        logic [StatusW-1:0] fix_st;
        logic               neg;
        logic               huge;
        logic               up;
        logic [63:0]        ipart;
        t_cls               cls;
        logic               sgn;
        logic               dbl;
    } t_item;

endpackage

FILE: rtl/core/f2i_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_front: unpacks the float and splits its magnitude
// Decodes fields and special values, aligns the mantissa and registers the
// integer part with its round-up bit.
// ----------------------------------------------------------------------------
module f2i_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  logic [f2i_pkg::FloatW-1:0]    i_float_bits,
    input  logic [f2i_pkg::CfgDatW-1:0]   i_source_width,
    input  logic [f2i_pkg::CfgDatW-1:0]   i_dest_width,
    input  logic                          i_dest_signed,
    output logic                          o_valid,
    output f2i_pkg::t_item                o_item
);

    logic           r_valid;
    f2i_pkg::t_item r_item, n_item;

    logic        dbl, neg, exp_max, exp_zero, frac_zero;
    logic [10:0] expo;
    logic [52:0] mant;
    logic [12:0] e;        // signed exponent of mantissa lsb
    logic [63:0] ip, rem, half;
    logic [5:0]  sh;

    always_comb begin
        n_item = '0;
        dbl    = (i_source_width == 7'd64);
        if (dbl) begin
            neg       = i_float_bits[63];
            expo      = i_float_bits[62:52];
            frac_zero = (i_float_bits[51:0] == '0);
            exp_max   = (expo == 11'h7FF);
            mant      = {~(expo == '0), i_float_bits[51:0]};
            e = (expo == '0) ? 13'(-1074) : 13'({2'b0, expo}) - 13'd1075;
        end else begin
            neg       = i_float_bits[31];
            expo      = {3'b0, i_float_bits[30:23]};
            frac_zero = (i_float_bits[22:0] == '0);
            exp_max   = (expo[7:0] == 8'hFF);
            mant      = {29'b0, ~(expo == '0), i_float_bits[22:0]};
            e = (expo == '0) ? 13'(-149) : 13'({2'b0, expo}) - 13'd150;
        end
        exp_zero = (expo == '0);
        ip = '0; rem = '0; half = '0; sh = '0;
        n_item.huge = exp_max && frac_zero;
        if (!exp_max) begin
            if (!e[12]) begin
                if (e >= 13'd64) begin
                    n_item.huge = 1'b1;
                end else begin
                    ip = {11'b0, mant} << e[5:0];
                    // Bits lost off the top mean the value does not fit 64 bits.
                    if ((ip >> e[5:0]) != {11'b0, mant}) n_item.huge = 1'b1;
                end
            end else if (e > 13'(-64)) begin
                sh   = 6'(-e);
                ip   = {11'b0, mant} >> sh;
                rem  = {11'b0, mant} & ((64'd1 << sh) - 64'd1);
                half = 64'd1 << (sh - 6'd1);
                n_item.up = (rem >= half);
            end
        end
        n_item.ipart = ip;
        n_item.neg   = neg;
        n_item.dbl   = dbl;
        n_item.sgn   = i_dest_signed;
        if (i_dest_width <= 7'd8)       n_item.cls = f2i_pkg::CLS_8;
        else if (i_dest_width <= 7'd16) n_item.cls = f2i_pkg::CLS_16;
        else if (i_dest_width <= 7'd32) n_item.cls = f2i_pkg::CLS_32;
        else                            n_item.cls = f2i_pkg::CLS_64;
        if (i_dest_width > 7'd64 || (!dbl && i_source_width != 7'd32)) begin
            n_item.fixed  = 1'b1;
            n_item.fix_st = f2i_pkg::ST_UNSUPPORTED;
        end else if (!i_dest_signed && (neg || (exp_max && !frac_zero)
                     || (exp_zero && frac_zero))) begin
            n_item.fixed  = 1'b1;
            n_item.fix_st = f2i_pkg::ST_NEG_UNSIGNED;
        end else if (exp_max && !frac_zero) begin
            n_item.fixed  = 1'b1;
            n_item.fix_st = f2i_pkg::ST_NAN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_valid <= 1'b0;
        else          r_valid <= i_push;
        if (i_push) r_item <= n_item;
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

FILE: rtl/core/f2i_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_queue: short queue between the front and back ends
// A small register queue of classified items with a fill count.
// ----------------------------------------------------------------------------
module f2i_queue #(
    parameter int Depth = f2i_pkg::DefQueueDepth
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  f2i_pkg::t_item i_item,
    input  logic           i_pop,
    output logic           o_empty,
    output logic [$clog2(Depth+1)-1:0] o_count,
    output f2i_pkg::t_item o_item
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    f2i_pkg::t_item r_mem [Depth];
    logic [PtrW-1:0] r_wp, r_rp;
    logic [CntW-1:0] r_cnt;

    function automatic logic [PtrW-1:0] inc(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= inc(r_wp);
            if (i_pop)  r_rp <= inc(r_rp);
            r_cnt <= r_cnt + CntW'(i_push) - CntW'(i_pop);
        end
        if (i_push) r_mem[r_wp] <= i_item;
    end

    assign o_empty = (r_cnt == '0);
    assign o_count = r_cnt;
    assign o_item  = r_mem[r_rp];

endmodule

FILE: rtl/core/f2i_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// f2i_back: rounding and saturation
// Applies the class limits and rounding to a classified item.
// ----------------------------------------------------------------------------
module f2i_back (
    input  f2i_pkg::t_item               i_item,
    output logic [63:0]                  o_int_value,
    output logic [f2i_pkg::StatusW-1:0]  o_status
);

    logic [63:0] mask, maxv, thr, minmag, r;
    logic        thr_huge;
    logic [6:0]  k, prec;

    always_comb begin
        case (i_item.cls)
            f2i_pkg::CLS_8:  begin mask = 64'hFF;       minmag = 64'h80; end
            f2i_pkg::CLS_16: begin mask = 64'hFFFF;     minmag = 64'h8000; end
            f2i_pkg::CLS_32: begin mask = 64'hFFFF_FFFF; minmag = 64'h8000_0000; end
            default:         begin mask = '1;           minmag = 64'h1 << 63; end
        endcase
        k    = i_item.sgn ? 7'(2 ** (int'(i_item.cls) + 3) - 1)
                          : 7'(2 ** (int'(i_item.cls) + 3));
        maxv = i_item.sgn ? (mask >> 1) : mask;
        prec = i_item.dbl ? 7'd53 : 7'd24;
        thr_huge = 1'b0;
        thr = maxv;
        if (k > prec) begin
            if (k == 7'd64) thr_huge = 1'b1;
            else            thr = maxv + 64'd1;
        end
        r = i_item.ipart + 64'(i_item.up);
        if (i_item.fixed) begin
            o_int_value = '0;
            o_status    = i_item.fix_st;
        end else if (!i_item.neg) begin
            if (i_item.huge || (!thr_huge && i_item.ipart >= thr)) begin
                o_int_value = maxv;
                o_status    = f2i_pkg::ST_SAT_MAX;
            end else begin
                o_int_value = ((r > maxv) ? maxv : r) & mask;
                o_status    = f2i_pkg::ST_ROUNDED;
            end
        end else if (i_item.huge || i_item.ipart >= minmag) begin
            o_int_value = (64'd0 - minmag) & mask;
            o_status    = f2i_pkg::ST_SAT_MIN;
        end else begin
            o_int_value = (64'd0 - ((r > minmag) ? minmag : r)) & mask;
            o_status    = f2i_pkg::ST_ROUNDED;
        end
    end

endmodule

FILE: rtl/core/float_to_int_saturating_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// float_to_int_saturating_round: IEEE float to saturated integer
// Converts single or double bits to an 8/16/32/64-bit integer, rounding half
// away from zero and saturating at the class limits, with a status code.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  ---------+----------------------+------------------------------
//  input    | i_push / o_full      | i_float_bits
//  result   | o_empty / i_pop      | o_int_value, o_status
//  config   | i_cfg_valid/o_cfg_ready | i_cfg_index, i_cfg_data
//
// One transaction per cycle is sustained in both directions while full is low.
// The front end registers the classified item when the push is accepted and
// the queue takes it from that register; the back end is pure logic on the
// head of the queue, so a result is on the ports as soon as its item is in
// the queue. Reset (synchronous, active low) empties the pipeline and
// restores the registers to single source, 32-bit signed destination. When
// pop stalls, the queue fills and full rises once the queue has room left
// only for the item still in the front register.
// ----------------------------------------------------------------------------
module float_to_int_saturating_round #(
    parameter int QueueDepth = f2i_pkg::DefQueueDepth + 1
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic [f2i_pkg::FloatW-1:0]    i_float_bits,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [63:0]                   o_int_value,
    output logic [f2i_pkg::StatusW-1:0]   o_status,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [f2i_pkg::CfgIdxW-1:0]   i_cfg_index,
    input  logic [f2i_pkg::CfgDatW-1:0]   i_cfg_data
);

    localparam int CntW = $clog2(QueueDepth + 1);

    logic [f2i_pkg::CfgDatW-1:0] r_source_width, r_dest_width;
    logic                        r_dest_signed;

    logic           fr_valid, q_pop;
    f2i_pkg::t_item fr_item, q_item;
    logic [CntW-1:0] q_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_source_width <= 7'd32;
            r_dest_width   <= 7'd32;
            r_dest_signed  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                f2i_pkg::REG_SOURCE_WIDTH: r_source_width <= i_cfg_data;
                f2i_pkg::REG_DEST_WIDTH:   r_dest_width   <= i_cfg_data;
                f2i_pkg::REG_DEST_SIGNED:  r_dest_signed  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // Room is kept for the item that may sit in the front register.
    assign o_full = (q_count >= CntW'(QueueDepth - 1));
    assign q_pop  = i_pop && !o_empty;

    f2i_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (i_push && !o_full),
        .i_float_bits   (i_float_bits),
        .i_source_width (r_source_width),
        .i_dest_width   (r_dest_width),
        .i_dest_signed  (r_dest_signed),
        .o_valid        (fr_valid),
        .o_item         (fr_item)
    );

    f2i_queue #(.Depth(QueueDepth)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (fr_valid),
        .i_item  (fr_item),
        .i_pop   (q_pop),
        .o_empty (o_empty),
        .o_count (q_count),
        .o_item  (q_item)
    );

    f2i_back u_back (
        .i_item      (q_item),
        .o_int_value (o_int_value),
        .o_status    (o_status)
    );

endmodule
